// File: rtl/q2r_pkg.sv
// Shared widths, constants and stage payload types for the quaternion to
// rotation matrix pipeline. No dependencies.
package q2r_pkg;

  localparam int CW = 16;          // component width
  localparam int FB = 14;          // fraction bits
  localparam int PW = 2 * CW;      // product width
  localparam int NW = 2 * CW + 1;  // squared norm and numerator width
  localparam int QW = FB + 2;      // quotient bits: one integer, FB+1 fraction
  localparam int DS = FB + 2;      // division steps
  localparam int NE = 9;           // matrix elements

  localparam logic [NW-1:0] OneQ = NW'(1) << FB;
  localparam logic [NW-1:0] TopPos = (NW'(1) << (CW - 1)) - NW'(1);
  localparam logic [NW-1:0] TopNeg = NW'(1) << (CW - 1);
  localparam logic [QW-1:0] PosLim = (OneQ < TopPos) ? QW'(OneQ) : QW'(TopPos);
  localparam logic [QW-1:0] NegLim = (OneQ < TopNeg) ? QW'(OneQ) : QW'(TopNeg);

  typedef struct packed {
    logic [NE-1:0][NW-1:0] rem;
    logic [NE-1:0][QW-1:0] acc;
    logic [NE-1:0]         neg;
    logic [NW-1:0]         den;
    logic                  zero;
  } div_t;

endpackage

// File: rtl/q2r_products.sv
// Front end: squares and cross products, then norm and element numerators.
// Uses q2r_pkg.
module q2r_products import q2r_pkg::*; (
  input  logic                 clk,
  input  logic                 en_a,
  input  logic                 en_b,
  input  logic signed [CW-1:0] w_in,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [CW-1:0] z_in,
  output div_t                 div_out
);

  logic signed [CW-1:0] w, x, y, z;
  logic signed [PW-1:0] w2_r, x2_r, y2_r, z2_r;
  logic signed [PW-1:0] xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  div_t div_r, div_nxt;
  logic [NW-1:0] w2, x2, y2, z2;
  logic signed [NW-1:0] p [6];
  logic [NW-1:0] da [3];
  logic [NW-1:0] db [3];

  function automatic logic signed [CW-1:0] clip(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] lo;
    lo = {1'b1, {(CW-1){1'b0}}};
    if (CW >= 32 && v == lo) return lo + CW'(1);
    return v;
  endfunction

  assign w = clip(w_in);
  assign x = clip(x_in);
  assign y = clip(y_in);
  assign z = clip(z_in);

  always_ff @(posedge clk) begin
    if (en_a) begin
      w2_r <= w * w;
      x2_r <= x * x;
      y2_r <= y * y;
      z2_r <= z * z;
      xy_r <= x * y;
      wz_r <= w * z;
      xz_r <= x * z;
      wy_r <= w * y;
      yz_r <= y * z;
      wx_r <= w * x;
    end
  end

  always_comb begin
    w2 = NW'(unsigned'(w2_r));
    x2 = NW'(unsigned'(x2_r));
    y2 = NW'(unsigned'(y2_r));
    z2 = NW'(unsigned'(z2_r));
    p[0] = NW'(xy_r) - NW'(wz_r);
    p[1] = NW'(xz_r) + NW'(wy_r);
    p[2] = NW'(xy_r) + NW'(wz_r);
    p[3] = NW'(yz_r) - NW'(wx_r);
    p[4] = NW'(xz_r) - NW'(wy_r);
    p[5] = NW'(yz_r) + NW'(wx_r);
    da[0] = w2 + x2; db[0] = y2 + z2;
    da[1] = w2 + y2; db[1] = x2 + z2;
    da[2] = w2 + z2; db[2] = x2 + y2;
    div_nxt = '0;
    div_nxt.den  = w2 + x2 + y2 + z2;
    div_nxt.zero = (div_nxt.den == '0);
    for (int d = 0; d < 3; d++) begin
      div_nxt.neg[4*d] = da[d] < db[d];
      div_nxt.rem[4*d] = div_nxt.neg[4*d] ? db[d] - da[d] : da[d] - db[d];
    end
    for (int k = 0; k < 6; k++) begin
      // off-diagonal lanes 1,2,3,5,6,7
      div_nxt.neg[k + 1 + k / 3] = p[k][NW-1];
      div_nxt.rem[k + 1 + k / 3] = (p[k][NW-1] ? NW'(-p[k]) : NW'(p[k])) << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) div_r <= div_nxt;
  end

  assign div_out = div_r;

endmodule

// File: rtl/q2r_div_step.sv
// One restoring-division step across all nine lanes, registered.
// Uses q2r_pkg.
module q2r_div_step import q2r_pkg::*; (
  input  logic clk,
  input  logic en,
  input  logic first,   // integer bit: compare without doubling
  input  div_t div_in,
  output div_t div_out
);

  div_t div_r, div_nxt;
  logic [NW:0] t;
  logic        b;

  always_comb begin
    div_nxt = div_in;
    t = '0;
    b = 1'b0;
    for (int i = 0; i < NE; i++) begin
      t = first ? {1'b0, div_in.rem[i]} : {div_in.rem[i], 1'b0};
      b = t >= {1'b0, div_in.den};
      div_nxt.rem[i] = b ? NW'(t - {1'b0, div_in.den}) : NW'(t);
      div_nxt.acc[i] = {div_in.acc[i][QW-2:0], b};
    end
  end

  always_ff @(posedge clk) begin
    if (en) div_r <= div_nxt;
  end

  assign div_out = div_r;

endmodule

// File: rtl/q2r_finish.sv
// Output stage: round half away from zero, clamp to [-1,1], apply sign,
// substitute identity for a zero quaternion. Uses q2r_pkg.
module q2r_finish import q2r_pkg::*; (
  input  logic                       clk,
  input  logic                       en,
  input  div_t                       div_in,
  output logic [NE-1:0][CW-1:0]      m_out,
  output logic                       zero_out
);

  logic [NE-1:0][CW-1:0] m_r, m_nxt;
  logic                  zero_r;
  logic [QW:0]           q;
  logic [QW-1:0]         lim, qs;

  always_comb begin
    q = '0; lim = '0; qs = '0;
    for (int i = 0; i < NE; i++) begin
      q   = ({1'b0, div_in.acc[i]} + (QW+1)'(1)) >> 1;
      lim = div_in.neg[i] ? NegLim : PosLim;
      qs  = (q > {1'b0, lim}) ? lim : QW'(q);
      if (div_in.zero)
        m_nxt[i] = (i % 4 == 0) ? CW'(PosLim) : '0;
      else
        m_nxt[i] = div_in.neg[i] ? CW'(-qs) : CW'(qs);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= m_nxt;
      zero_r <= div_in.zero;
    end
  end

  assign m_out    = m_r;
  assign zero_out = zero_r;

endmodule

// File: rtl/quaternion_to_rotation_matrix_core.sv
// Quaternion to 3x3 rotation matrix, fully pipelined top level.
// Uses q2r_pkg, q2r_products, q2r_div_step, q2r_finish.
//
// Usage notes:
// - Input beat: q_scalar, q_vec_x/y/z, signed Q1.14, taken when in_valid is
//   high and in_stall low. Output beat: m00..m22 (signed Q1.14, clamped to
//   [-1,1]) and zero_input, taken when out_valid is high and out_stall low.
// - Each element is an exact ratio num/|q|^2 worked out by a 16-step
//   restoring divider, one quotient bit per pipeline stage, nine lanes wide.
// - Depth: 19 register stages (products, sums, 16 divide steps,
//   rounding/output register).
// - Throughput: one beat per cycle while out_stall is low; the divider
//   stages set the depth, the 16x16 multipliers the front end.
// - A zero quaternion gives the identity with zero_input set.
// - Each stage has its own valid bit and advances when it is empty or the
//   next stage moves, so bubbles close up under a stall and a held output
//   beat does not stop earlier stages filling.
// - in_stall rises only when every stage holds a beat and out_stall is high.
// - Synchronous active-low reset empties all stages; payload is not reset.
module quaternion_to_rotation_matrix_core import q2r_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] in_q_scalar,
  input  logic signed [CW-1:0] in_q_vec_x,
  input  logic signed [CW-1:0] in_q_vec_y,
  input  logic signed [CW-1:0] in_q_vec_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [CW-1:0] out_m00,
  output logic signed [CW-1:0] out_m01,
  output logic signed [CW-1:0] out_m02,
  output logic signed [CW-1:0] out_m10,
  output logic signed [CW-1:0] out_m11,
  output logic signed [CW-1:0] out_m12,
  output logic signed [CW-1:0] out_m20,
  output logic signed [CW-1:0] out_m21,
  output logic signed [CW-1:0] out_m22,
  output logic                 out_zero_input
);

  localparam int NS = DS + 3;  // products, sums, divide steps, output

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;
  div_t          dv [DS+1];
  logic [NE-1:0][CW-1:0] m;

  // stage k may load when empty or when its beat moves on
  assign rdy[NS] = ~out_stall;
  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_rdy
      assign rdy[k] = ~v_r[k] | rdy[k+1];
    end
  endgenerate

  assign vin = {v_r[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) v_r[i] <= vin[i];
      end
    end
  end

  q2r_products u_prod (
    .clk     (clk),
    .en_a    (rdy[0]),
    .en_b    (rdy[1]),
    .w_in    (in_q_scalar),
    .x_in    (in_q_vec_x),
    .y_in    (in_q_vec_y),
    .z_in    (in_q_vec_z),
    .div_out (dv[0])
  );

  generate
    for (k = 0; k < DS; k++) begin : g_div
      q2r_div_step u_step (
        .clk     (clk),
        .en      (rdy[k+2]),
        .first   (k == 0),
        .div_in  (dv[k]),
        .div_out (dv[k+1])
      );
    end
  endgenerate

  q2r_finish u_fin (
    .clk      (clk),
    .en       (rdy[NS-1]),
    .div_in   (dv[DS]),
    .m_out    (m),
    .zero_out (out_zero_input)
  );

  assign in_stall  = ~rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_m00 = m[0];
  assign out_m01 = m[1];
  assign out_m02 = m[2];
  assign out_m10 = m[3];
  assign out_m11 = m[4];
  assign out_m12 = m[5];
  assign out_m20 = m[6];
  assign out_m21 = m[7];
  assign out_m22 = m[8];

endmodule
